// ===== hdl/framed_packet_case_converter_core_macros.svh =====
// Assertion macros shared by the framed packet case converter RTL.
`ifndef FRAMED_PACKET_CASE_CONVERTER_CORE_MACROS_SVH
`define FRAMED_PACKET_CASE_CONVERTER_CORE_MACROS_SVH

// Same-cycle implication.
`define FPCC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fpcc assertion failed");

// Next-cycle implication.
`define FPCC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fpcc assertion failed");

`endif

// ===== hdl/fpcc_pkg.sv =====
// Types, constants and the case conversion function of the packet case converter.
`default_nettype none
package fpcc_pkg;

   localparam logic [7:0] CHAR_OFFSET = 8'd48;
   localparam logic [7:0] CASE_SHIFT  = 8'd32;
   localparam logic [7:0] LOWER_FIRST = 8'h61;
   localparam logic [7:0] LOWER_LAST  = 8'h7A;
   localparam logic [7:0] UPPER_FIRST = 8'h41;
   localparam logic [7:0] UPPER_LAST  = 8'h5A;

   localparam logic [7:0] REG_START_VALUE       = 8'd0;
   localparam logic [7:0] REG_END_VALUE         = 8'd1;
   localparam logic [7:0] REG_HIGHEST_OPERATION = 8'd2;
   localparam logic [7:0] REG_UPPER_OPERATION   = 8'd3;
   localparam logic [7:0] REG_LOWER_OPERATION   = 8'd4;

   typedef struct packed {
      logic [7:0] start_value;
      logic [7:0] end_value;
      logic [7:0] highest_operation;
      logic [7:0] upper_operation;
      logic [7:0] lower_operation;
   } cfg_type;

   // Frame closed: start readout.
   typedef struct packed {
      logic       start;
      logic [7:0] operation;
      logic       to_upper;
      logic       to_lower;
   } frame_done_type;

   function automatic logic [7:0] convert_byte(input logic [7:0] b,
                                               input logic to_upper,
                                               input logic to_lower);
      logic [7:0] r;
      r = b;
      if (to_upper && b >= LOWER_FIRST && b <= LOWER_LAST) begin
         r = b - CASE_SHIFT;
      end else if (to_lower && b >= UPPER_FIRST && b <= UPPER_LAST) begin
         r = b + CASE_SHIFT;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== hdl/fpcc_channels.sv =====
// Stream and register write channel interfaces of the packet case converter.
`default_nettype none
interface fpcc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface fpcc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] payload_byte;
   logic [7:0] frame_operation;
   logic       last_byte;
   modport source (output valid, output payload_byte, output frame_operation,
                   output last_byte, input ready);
   modport sink (input valid, input payload_byte, input frame_operation,
                 input last_byte, output ready);
endinterface

interface fpcc_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] index;
   logic [7:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/fpcc_payload_ram.sv =====
// Payload store: one write port, one registered read port.
`default_nettype none
module fpcc_payload_ram #(
   parameter int unsigned DEPTH  = 64,
   parameter int unsigned ADDR_W = 6
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [7:0]        wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]             rd_data
);

   logic [7:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Hold read data until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ===== hdl/fpcc_parser.sv =====
// Frame parser: tracks start, operation, length, payload and end bytes.
`default_nettype none
module fpcc_parser import fpcc_pkg::*; #(
   parameter int unsigned PAYLOAD_DEPTH = 64,
   parameter int unsigned CNT_W         = 7,
   parameter int unsigned ADDR_W        = 6
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic [7:0]        rx_byte,
   input  wire cfg_type           cfg,
   output logic                   wr_en,
   output logic [ADDR_W-1:0]      wr_addr,
   output logic [7:0]             wr_data,
   output frame_done_type         done,
   output logic [CNT_W-1:0]       done_len
);

   typedef enum logic [2:0] {
      PH_START,
      PH_OP,
      PH_LEN,
      PH_DATA,
      PH_END
   } phase_type;

   phase_type        phase_ff;
   logic [7:0]       op_ff;
   logic [CNT_W-1:0] len_ff;
   logic [CNT_W-1:0] count_ff;

   logic             above;
   logic [7:0]       val;
   logic             len_ok;
   logic [CNT_W-1:0] count_in;
   logic             end_ok;

   assign above    = rx_byte >= CHAR_OFFSET;
   assign val      = rx_byte - CHAR_OFFSET;
   assign len_ok   = above && (val != 8'd0) && ({1'b0, val} <= 9'(PAYLOAD_DEPTH));
   assign count_in = count_ff + CNT_W'(1);
   assign end_ok   = above && (val == cfg.end_value);

   assign wr_en   = accept && (phase_ff == PH_DATA);
   assign wr_addr = count_ff[ADDR_W-1:0];
   assign wr_data = rx_byte;

   always_comb begin
      done.start     = accept && (phase_ff == PH_END) && end_ok;
      done.operation = op_ff;
      done.to_upper  = (op_ff == cfg.upper_operation);
      done.to_lower  = (op_ff != cfg.upper_operation) && (op_ff == cfg.lower_operation);
   end
   assign done_len = len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START;
         op_ff    <= '0;
         len_ff   <= '0;
         count_ff <= '0;
      end else if (accept) begin
         case (phase_ff)
            PH_START: begin
               if (above && val == cfg.start_value) begin
                  phase_ff <= PH_OP;
               end
            end
            PH_OP: begin
               if (above && val <= cfg.highest_operation) begin
                  op_ff    <= val;
                  phase_ff <= PH_LEN;
               end else begin
                  phase_ff <= PH_START;
                  op_ff    <= '0;
                  len_ff   <= '0;
                  count_ff <= '0;
               end
            end
            PH_LEN: begin
               if (len_ok) begin
                  len_ff   <= val[CNT_W-1:0];
                  count_ff <= '0;
                  phase_ff <= PH_DATA;
               end else begin
                  phase_ff <= PH_START;
                  op_ff    <= '0;
                  len_ff   <= '0;
                  count_ff <= '0;
               end
            end
            PH_DATA: begin
               count_ff <= count_in;
               if (count_in == len_ff) begin
                  phase_ff <= PH_END;
               end
            end
            default: begin
               // End byte, good or bad: drop frame state.
               phase_ff <= PH_START;
               op_ff    <= '0;
               len_ff   <= '0;
               count_ff <= '0;
            end
         endcase
      end
   end

endmodule
`default_nettype wire

// ===== hdl/fpcc_readout.sv =====
// Readout: streams stored payload through a read stage and an output register.
`default_nettype none
module fpcc_readout import fpcc_pkg::*; #(
   parameter int unsigned CNT_W  = 7,
   parameter int unsigned ADDR_W = 6
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire frame_done_type    done,
   input  wire logic [CNT_W-1:0]  done_len,
   output logic                   busy,
   output logic                   rd_en,
   output logic [ADDR_W-1:0]      rd_addr,
   input  wire logic [7:0]        rd_data,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output logic [7:0]             out_byte,
   output logic [7:0]             out_op,
   output logic                   out_last
);

   logic             busy_ff;
   logic [CNT_W-1:0] idx_ff;
   logic [CNT_W-1:0] len_ff;
   logic [7:0]       op_ff;
   logic             up_ff;
   logic             lo_ff;

   logic             s1_vld_ff;
   logic             s1_last_ff;
   logic [7:0]       s1_op_ff;
   logic             s1_up_ff;
   logic             s1_lo_ff;

   logic             out_vld_ff;
   logic [7:0]       out_byte_ff;
   logic [7:0]       out_op_ff;
   logic             out_last_ff;

   logic             out_load;
   logic             s1_free;
   logic             issue;
   logic             issue_last;

   assign out_load   = s1_vld_ff && (!out_vld_ff || out_ready);
   assign s1_free    = !s1_vld_ff || out_load;
   assign issue      = busy_ff && s1_free;
   assign issue_last = (idx_ff == len_ff - CNT_W'(1));

   assign busy    = busy_ff;
   assign rd_en   = issue;
   assign rd_addr = idx_ff[ADDR_W-1:0];

   assign out_valid = out_vld_ff;
   assign out_byte  = out_byte_ff;
   assign out_op    = out_op_ff;
   assign out_last  = out_last_ff;

   // Read issue counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else if (done.start) begin
         busy_ff <= 1'b1;
         idx_ff  <= '0;
      end else if (issue) begin
         idx_ff <= idx_ff + CNT_W'(1);
         if (issue_last) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (done.start) begin
         len_ff <= done_len;
         op_ff  <= done.operation;
         up_ff  <= done.to_upper;
         lo_ff  <= done.to_lower;
      end
   end

   // Read stage: the RAM holds the data, this holds its tags.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (issue) begin
         s1_vld_ff <= 1'b1;
      end else if (out_load) begin
         s1_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         s1_last_ff <= issue_last;
         s1_op_ff   <= op_ff;
         s1_up_ff   <= up_ff;
         s1_lo_ff   <= lo_ff;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (out_load) begin
         out_vld_ff <= 1'b1;
      end else if (out_ready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_byte_ff <= convert_byte(rd_data, s1_up_ff, s1_lo_ff);
         out_op_ff   <= s1_op_ff;
         out_last_ff <= s1_last_ff;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/framed_packet_case_converter_core.sv =====
// Top level of the framed packet case converter.
//
// req_ch carries one received byte per word (valid/ready). Frames are
// start code, operation code, length, payload bytes, end code, with the
// control bytes read as byte minus 48. Payload bytes go into a
// PAYLOAD_DEPTH-entry RAM as they arrive.
// rsp_ch gives one word per payload byte once the end code is accepted:
// the byte cased up, down or kept by operation, the operation, and a last
// flag on the final byte. The first word is valid once readout has gone
// busy, read the RAM through the read stage and loaded the output register;
// words then follow one per cycle while rsp_ch is ready. req_ch.ready stays
// low while read addresses are being issued, also while a stalled receiver
// holds readout; otherwise one byte is accepted per cycle.
// csr_ch writes the five 8-bit registers; it is always ready, and writes
// to unknown indexes are dropped.
// Reset (synchronous) restores register defaults, returns the parser to
// waiting for a start code and empties the readout pipeline. The RAM is
// not cleared; only entries written in the current frame are read.
// A stalled receiver holds the output word; the read stage behind it
// holds one more, and readout waits.
`default_nettype none
`include "framed_packet_case_converter_core_macros.svh"
module framed_packet_case_converter_core import fpcc_pkg::*; #(
   parameter int unsigned PAYLOAD_DEPTH = 64
) (
   input  wire logic clock,
   input  wire logic reset,
   fpcc_req_if.sink   req_ch,
   fpcc_rsp_if.source rsp_ch,
   fpcc_csr_if.sink   csr_ch
);

   localparam int unsigned CNT_W  = $clog2(PAYLOAD_DEPTH + 1);
   localparam int unsigned ADDR_W = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;

   cfg_type          cfg_ff;
   logic             rd_busy;
   logic             accept;
   logic             wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [7:0]       wr_data;
   logic             rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [7:0]       rd_data;
   frame_done_type   done;
   logic [CNT_W-1:0] done_len;

   // Hold input off while readout owns the RAM.
   assign req_ch.ready = !rd_busy;
   assign accept       = req_ch.valid && !rd_busy;
   assign csr_ch.ready = 1'b1;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_value       <= 8'd2;
         cfg_ff.end_value         <= 8'd3;
         cfg_ff.highest_operation <= 8'd4;
         cfg_ff.upper_operation   <= 8'd0;
         cfg_ff.lower_operation   <= 8'd1;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            REG_START_VALUE:       cfg_ff.start_value       <= csr_ch.data;
            REG_END_VALUE:         cfg_ff.end_value         <= csr_ch.data;
            REG_HIGHEST_OPERATION: cfg_ff.highest_operation <= csr_ch.data;
            REG_UPPER_OPERATION:   cfg_ff.upper_operation   <= csr_ch.data;
            REG_LOWER_OPERATION:   cfg_ff.lower_operation   <= csr_ch.data;
            default: begin
               // Drop writes to unknown indexes.
            end
         endcase
      end
   end

   fpcc_parser #(
      .PAYLOAD_DEPTH (PAYLOAD_DEPTH),
      .CNT_W         (CNT_W),
      .ADDR_W        (ADDR_W)
   ) u_parser (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .rx_byte  (req_ch.rx_byte),
      .cfg      (cfg_ff),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .done     (done),
      .done_len (done_len)
   );

   fpcc_payload_ram #(
      .DEPTH  (PAYLOAD_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   fpcc_readout #(
      .CNT_W  (CNT_W),
      .ADDR_W (ADDR_W)
   ) u_readout (
      .clock     (clock),
      .reset     (reset),
      .done      (done),
      .done_len  (done_len),
      .busy      (rd_busy),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_byte  (rsp_ch.payload_byte),
      .out_op    (rsp_ch.frame_operation),
      .out_last  (rsp_ch.last_byte)
   );

   `FPCC_ASSERT_SAME(a_no_write_during_readout, clock, reset, wr_en, !rd_busy)
   `FPCC_ASSERT_SAME(a_no_read_while_idle, clock, reset, rd_en, rd_busy)
   `FPCC_ASSERT_SAME(a_frame_done_when_idle, clock, reset, done.start, !rd_busy)
   `FPCC_ASSERT_NEXT(a_frame_done_starts_readout, clock, reset, done.start, rd_busy)

endmodule
`default_nettype wire

// ===== tb/sv/framed_packet_case_converter_core_tb.sv =====
// Self-checking testbench for the framed packet case converter core.
`default_nettype none
module framed_packet_case_converter_core_tb import fpcc_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned PAYLOAD_DEPTH = 64;
   // Allow the readout registers and the read stage to empty, with margin.
   localparam int SETTLE_CYCLES = 12;
   // Long receiver hold-off, so that the readout backs up into req_ch.
   localparam int LONG_HOLD = 400;
   localparam int PHASE_COUNT = 7;
   localparam int SCRIPT_ROWS = 28;
   // Register indexes that the block must ignore.
   localparam logic [7:0] BAD_INDEX_LOW = 8'd5;
   localparam logic [7:0] BAD_INDEX_HIGH = 8'hFF;

   localparam cfg_type RESET_REGS = '{8'd2, 8'd3, 8'd4, 8'd0, 8'd1};

   // One result word as the receiver sees it.
   typedef struct packed {
      logic [7:0] payload;
      logic [7:0] operation;
      logic       last;
   } out_word_type;

   localparam out_word_type NO_WORD = '{8'h00, 8'h00, 1'b0};

   // One row of the directed script: a received byte, and where the outcome is
   // plain, the single word it must release.
   typedef struct packed {
      logic [7:0]   rx;
      logic         typed;
      out_word_type want;
   } script_row_type;

   typedef enum logic [2:0] {
      AWAIT_START,
      AWAIT_OP,
      AWAIT_LEN,
      TAKE_PAYLOAD,
      AWAIT_END
   } parse_state_type;

   logic clock;
   logic reset;

   fpcc_req_if req_ch();
   fpcc_rsp_if rsp_ch();
   fpcc_csr_if csr_ch();

   framed_packet_case_converter_core #(.PAYLOAD_DEPTH(PAYLOAD_DEPTH)) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Shadow of the block: registers, parser state and payload buffer.
   cfg_type         regs = RESET_REGS;
   parse_state_type parse_state = AWAIT_START;
   logic [7:0]      op_held = '0;
   int              len_held = 0;
   int              got = 0;
   logic [7:0]      stash [PAYLOAD_DEPTH];

   // Words still owed by the block, oldest first.
   out_word_type pending_words[$];

   int mismatches = 0;
   int bytes_sent = 0;
   bit quiet = 1'b0;        // no idling on either side
   bit hold_request = 1'b0; // ask the receiver for one long hold-off

   // Directed script, run with the reset register values: start '2', end '3',
   // operations 0..4, upper on 0, lower on 1.
   script_row_type script [SCRIPT_ROWS] = '{
      // Upper-case frame, one byte: 'z' comes out as 'Z', last set.
      '{8'h32, 1'b0, NO_WORD}, '{8'h30, 1'b0, NO_WORD}, '{8'h31, 1'b0, NO_WORD},
      '{8'h7A, 1'b0, NO_WORD}, '{8'h33, 1'b1, '{8'h5A, 8'd0, 1'b1}},
      // Lower-case frame, one byte: 'A' comes out as 'a'.
      '{8'h32, 1'b0, NO_WORD}, '{8'h31, 1'b0, NO_WORD}, '{8'h31, 1'b0, NO_WORD},
      '{8'h41, 1'b0, NO_WORD}, '{8'h33, 1'b1, '{8'h61, 8'd1, 1'b1}},
      // Highest operation passes bytes through; top byte value in the payload.
      '{8'h32, 1'b0, NO_WORD}, '{8'h34, 1'b0, NO_WORD}, '{8'h32, 1'b0, NO_WORD},
      '{8'h61, 1'b0, NO_WORD}, '{8'hFF, 1'b0, NO_WORD}, '{8'h33, 1'b0, NO_WORD},
      // Operation byte below the offset: frame dropped.
      '{8'h32, 1'b0, NO_WORD}, '{8'h2F, 1'b0, NO_WORD},
      // Operation above the highest one: frame dropped.
      '{8'h32, 1'b0, NO_WORD}, '{8'h35, 1'b0, NO_WORD},
      // Zero length: frame dropped.
      '{8'h32, 1'b0, NO_WORD}, '{8'h30, 1'b0, NO_WORD}, '{8'h30, 1'b0, NO_WORD},
      // Byte below the offset where the end code belongs: nothing released.
      '{8'h32, 1'b0, NO_WORD}, '{8'h30, 1'b0, NO_WORD}, '{8'h31, 1'b0, NO_WORD},
      '{8'h78, 1'b0, NO_WORD}, '{8'h00, 1'b0, NO_WORD}
   };

   cfg_type settings [PHASE_COUNT] = '{
      '{8'd0,   8'd207, 8'd207, 8'd207, 8'd0},  // extremes
      '{8'd207, 8'd0,   8'd0,   8'd9,   8'd0},  // only operation 0 allowed
      '{8'd5,   8'd5,   8'd10,  8'd7,   8'd7},  // same code on both: upper wins
      '{8'd255, 8'd3,   8'd4,   8'd0,   8'd1},  // start out of reach: no frame opens
      '{8'd1,   8'd208, 8'd20,  8'd3,   8'd3},  // end out of reach: no frame closes
      '{8'd0,   8'd0,   8'd0,   8'd0,   8'd0},  // randomized at run time
      '{8'd2,   8'd3,   8'd4,   8'd0,   8'd1}   // back to defaults
   };
   int budget [PHASE_COUNT] = '{16, 10, 10, 6, 6, 85, 16};

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Run limit, far above the slowest legal run.
   initial begin
      #5_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   task automatic note_mismatch(input string what);
      mismatches++;
      if (mismatches <= 40) $display("mismatch: %s", what);
   endtask

   function automatic void drop_frame();
      parse_state = AWAIT_START;
      op_held = '0;
      len_held = 0;
      got = 0;
   endfunction

   // Case conversion of one payload byte for the held operation.
   function automatic logic [7:0] recase(input logic [7:0] b);
      if (op_held == regs.upper_operation) begin
         return (b >= LOWER_FIRST && b <= LOWER_LAST) ? b - CASE_SHIFT : b;
      end
      if (op_held == regs.lower_operation) begin
         return (b >= UPPER_FIRST && b <= UPPER_LAST) ? b + CASE_SHIFT : b;
      end
      return b;
   endfunction

   // Advance the frame parser by one byte; append any words it releases.
   task automatic advance_parser(input logic [7:0] raw, ref out_word_type produced[$]);
      int v;
      v = int'(raw) - int'(CHAR_OFFSET);
      case (parse_state)
         AWAIT_START: begin
            if (v >= 0 && v == int'(regs.start_value)) parse_state = AWAIT_OP;
         end
         AWAIT_OP: begin
            if (v >= 0 && v <= int'(regs.highest_operation)) begin
               op_held = v[7:0];
               parse_state = AWAIT_LEN;
            end else begin
               drop_frame();
            end
         end
         AWAIT_LEN: begin
            if (v > 0 && v <= int'(PAYLOAD_DEPTH)) begin
               len_held = v;
               got = 0;
               parse_state = TAKE_PAYLOAD;
            end else begin
               drop_frame();
            end
         end
         TAKE_PAYLOAD: begin
            stash[got] = raw;
            got++;
            if (got == len_held) parse_state = AWAIT_END;
         end
         AWAIT_END: begin
            if (v >= 0 && v == int'(regs.end_value)) begin
               for (int k = 0; k < len_held; k++) begin
                  produced.push_back('{recase(stash[k]), op_held, k == len_held - 1});
               end
            end
            drop_frame();
         end
         default: drop_frame();
      endcase
   endtask

   function automatic void latch_reg(input logic [7:0] idx, input logic [7:0] val);
      case (idx)
         REG_START_VALUE:       regs.start_value = val;
         REG_END_VALUE:         regs.end_value = val;
         REG_HIGHEST_OPERATION: regs.highest_operation = val;
         REG_UPPER_OPERATION:   regs.upper_operation = val;
         REG_LOWER_OPERATION:   regs.lower_operation = val;
         default: ;
      endcase
   endfunction

   // Offer one byte, sometimes after a random gap, and hold it until accepted.
   // A typed row overrides the predicted words with the one written down.
   task automatic put_byte(input logic [7:0] b, input bit typed, input out_word_type want);
      int gap;
      out_word_type fresh[$];
      if (!quiet && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 11);
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.rx_byte <= b;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      bytes_sent++;
      advance_parser(b, fresh);
      if (typed) begin
         pending_words.push_back(want);
      end else begin
         foreach (fresh[i]) pending_words.push_back(fresh[i]);
      end
   endtask

   // Drop valid, wait for every owed word, then let the pipeline empty.
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write all five registers back to back; optionally add writes to indexes
   // the block must ignore.
   task automatic program_regs(input cfg_type c, input bit stray);
      logic [7:0] idx [7];
      logic [7:0] val [7];
      int n;
      idx = '{REG_START_VALUE, REG_END_VALUE, REG_HIGHEST_OPERATION,
              REG_UPPER_OPERATION, REG_LOWER_OPERATION, BAD_INDEX_LOW, BAD_INDEX_HIGH};
      val = '{c.start_value, c.end_value, c.highest_operation,
              c.upper_operation, c.lower_operation, 8'hFF, 8'h00};
      n = stray ? 7 : 5;
      for (int i = 0; i < n; i++) begin
         csr_ch.valid <= 1'b1;
         csr_ch.index <= idx[i];
         csr_ch.data <= val[i];
         @(posedge clock);
         while (!csr_ch.ready) @(posedge clock);
         latch_reg(idx[i], val[i]);
      end
      csr_ch.valid <= 1'b0;
   endtask

   function automatic logic [7:0] pick_letter();
      // Include the neighbors of both letter ranges.
      return $urandom_range(0, 1) ? 8'($urandom_range(8'h40, 8'h5B))
                                  : 8'($urandom_range(8'h60, 8'h7B));
   endfunction

   // Build and send one frame: mostly well formed for the current registers,
   // otherwise noise, a corrupted frame, or one with an illegal length.
   task automatic send_frame(input bit jumbo);
      logic [7:0] frame_bytes[$];
      int kind;
      int len;
      int sel;
      logic [7:0] op;
      kind = jumbo ? 0 : $urandom_range(0, 9);
      if (kind == 7) begin
         repeat ($urandom_range(1, 4)) frame_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
         sel = $urandom_range(0, 3);
         if (sel < 2) op = regs.upper_operation;
         else if (sel == 2) op = regs.lower_operation;
         else op = 8'($urandom_range(0, regs.highest_operation));
         if (jumbo) len = PAYLOAD_DEPTH;
         else if ($urandom_range(0, 7) == 0) len = $urandom_range(7, PAYLOAD_DEPTH);
         else len = $urandom_range(1, 6);
         frame_bytes.push_back(regs.start_value + CHAR_OFFSET);
         frame_bytes.push_back(op + CHAR_OFFSET);
         frame_bytes.push_back(8'(len) + CHAR_OFFSET);
         for (int k = 0; k < len; k++) begin
            frame_bytes.push_back($urandom_range(0, 1) ? pick_letter()
                                                       : 8'($urandom_range(0, 255)));
         end
         frame_bytes.push_back(regs.end_value + CHAR_OFFSET);
         if (kind == 8) begin
            frame_bytes[$urandom_range(0, frame_bytes.size() - 1)] = 8'($urandom_range(0, 255));
         end else if (kind == 9) begin
            // Length that is negative, zero or above the buffer depth.
            frame_bytes[2] = $urandom_range(0, 1) ? 8'($urandom_range(0, 48))
                                                  : 8'($urandom_range(113, 255));
         end
      end
      foreach (frame_bytes[i]) put_byte(frame_bytes[i], 1'b0, NO_WORD);
   endtask

   // Receiver: random stall bursts, one long hold-off on request, and a
   // steady ready while quiet.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (hold_request) begin
            hold_request = 1'b0;
            stall_left = LONG_HOLD - 1;
            rsp_ch.ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 10);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Compare every accepted result word with the oldest one owed.
   always @(posedge clock) begin
      out_word_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_words.size() == 0) begin
            note_mismatch($sformatf("unexpected word byte %h op %0d last %b",
                                    rsp_ch.payload_byte, rsp_ch.frame_operation,
                                    rsp_ch.last_byte));
         end else begin
            want = pending_words.pop_front();
            if (rsp_ch.payload_byte !== want.payload) begin
               note_mismatch($sformatf("payload_byte %h, want %h",
                                       rsp_ch.payload_byte, want.payload));
            end
            if (rsp_ch.frame_operation !== want.operation) begin
               note_mismatch($sformatf("frame_operation %0d, want %0d",
                                       rsp_ch.frame_operation, want.operation));
            end
            if (rsp_ch.last_byte !== want.last) begin
               note_mismatch($sformatf("last_byte %b, want %b",
                                       rsp_ch.last_byte, want.last));
            end
         end
      end
   end

   // Main sequence: reset, directed script, then register phases with random
   // frames, the last one without idling.
   initial begin
      bit first;
      int goal;
      req_ch.valid <= 1'b0;
      req_ch.rx_byte <= '0;
      csr_ch.valid <= 1'b0;
      csr_ch.index <= '0;
      csr_ch.data <= '0;
      reset <= 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the directed script with the reset register values.
      foreach (script[i]) put_byte(script[i].rx, script[i].typed, script[i].want);
      settle();

      // Randomize the sixth setting within the legal register range.
      settings[5].start_value = 8'($urandom_range(0, 207));
      settings[5].end_value = 8'($urandom_range(0, 207));
      settings[5].highest_operation = 8'($urandom_range(0, 207));
      settings[5].upper_operation = 8'($urandom_range(0, settings[5].highest_operation));
      settings[5].lower_operation = 8'($urandom_range(0, settings[5].highest_operation));

      for (int p = 0; p < PHASE_COUNT; p++) begin
         // Registers change only once every owed word is out and readout has emptied.
         program_regs(settings[p], p == 3);
         quiet = (p == PHASE_COUNT - 1);
         // Hold the receiver off while a full-depth frame and more come in.
         if (p == 5) begin
            // Bring the parser back to waiting for a start code first.
            while (parse_state != AWAIT_START) put_byte(8'h00, 1'b0, NO_WORD);
            hold_request = 1'b1;
         end
         goal = bytes_sent + budget[p];
         first = 1'b1;
         while (bytes_sent < goal) begin
            send_frame(p == 5 && first);
            first = 1'b0;
         end
         settle();
      end

      // Give a stray word time to show up.
      repeat (4 * SETTLE_CYCLES) @(posedge clock);
      if (pending_words.size() != 0) note_mismatch("words still owed at the end");
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
`default_nettype wire
